// ===== hw/rtl/plnc_pkg.sv =====
// Shared types and codes for the per-node packet loss accounting block.
`timescale 1ns / 1ps
`default_nettype none

package plnc_pkg;

    localparam int NODE_W = 6;
    localparam int SEQ_W  = 16;
    localparam int CNT_W  = 32;

    typedef enum logic [1:0] {
        ST_IGNORED  = 2'd0,
        ST_INVALID  = 2'd1,
        ST_ACCEPTED = 2'd2
    } t_status;

    // Decoded request, carried from the accept stage to the update stage.
    typedef struct packed {
        t_status             status;
        logic [NODE_W-1:0]   node;
        logic [7:0]          count;
        logic [SEQ_W-1:0]    seq;
    } t_class;

    // One node's stored record.
    typedef struct packed {
        logic [SEQ_W-1:0]    last_seq;
        logic [CNT_W-1:0]    packets;
        logic [CNT_W-1:0]    samples;
        logic [CNT_W-1:0]    lost;
        logic [CNT_W-1:0]    invalid;
    } t_entry;

    typedef struct packed {
        t_status             status;
        logic [NODE_W-1:0]   node_index;
        logic [SEQ_W-1:0]    missed_packets;
        logic [SEQ_W-1:0]    previous_sequence;
        logic [CNT_W-1:0]    packets_total;
        logic [CNT_W-1:0]    samples_total;
        logic [CNT_W-1:0]    lost_total;
        logic [CNT_W-1:0]    invalid_total;
    } t_result;

endpackage

`default_nettype wire

// ===== hw/rtl/plnc_channels.sv =====
// Request and result channel interfaces of the packet loss accounting block.
`timescale 1ns / 1ps
`default_nettype none

interface plnc_req_if;
    logic        valid;
    logic        ready;
    logic [7:0]  frame_type;
    logic [7:0]  frame_length;
    logic [7:0]  src_node;
    logic [15:0] sequence_req;
    logic [7:0]  smp_count;

    modport source (output valid, frame_type, frame_length, src_node, sequence_req,
                    smp_count, input ready);
    modport sink   (input valid, frame_type, frame_length, src_node, sequence_req,
                    smp_count, output ready);
endinterface

interface plnc_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [5:0]  node_index;
    logic [15:0] missed_packets;
    logic [15:0] previous_sequence;
    logic [31:0] packets_total;
    logic [31:0] samples_total;
    logic [31:0] lost_total;
    logic [31:0] invalid_total;

    modport source (output valid, status, node_index, missed_packets, previous_sequence,
                    packets_total, samples_total, lost_total, invalid_total, input ready);
    modport sink   (input valid, status, node_index, missed_packets, previous_sequence,
                    packets_total, samples_total, lost_total, invalid_total, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/plnc_classify.sv =====
// Header checks that sort a request into ignored, invalid or accepted.
`timescale 1ns / 1ps
`default_nettype none

module plnc_classify #(
    parameter int NODES        = 8,
    parameter int HEADER_BYTES = 16,
    parameter int MAX_SAMPLES  = 64
) (
    input  logic [7:0]      i_data_type_code,
    input  logic [7:0]      i_frame_type,
    input  logic [7:0]      i_frame_length,
    input  logic [7:0]      i_src_node,
    input  logic [15:0]     i_sequence_req,
    input  logic [7:0]      i_smp_count,
    output plnc_pkg::t_class o_class
);
    import plnc_pkg::*;

    localparam logic [9:0] MIN_LEN = 10'(HEADER_BYTES + 2);

    logic       sender_ok;
    logic       frame_ok;
    logic       count_bad;
    logic [9:0] want_len;

    always_comb begin
        sender_ok    = (i_src_node >= 8'd1) && (i_src_node <= 8'(NODES));
        want_len     = 10'(HEADER_BYTES) + {1'b0, i_smp_count, 1'b0};
        frame_ok     = (i_frame_length != 8'd0) && (i_frame_type == i_data_type_code)
                       && ({2'b00, i_frame_length} >= MIN_LEN);
        count_bad    = (i_smp_count == 8'd0) || (i_smp_count > 8'(MAX_SAMPLES))
                       || ({2'b00, i_frame_length} != want_len);

        o_class.node  = sender_ok ? NODE_W'(i_src_node - 8'd1) : '0;
        o_class.count = i_smp_count;
        o_class.seq   = i_sequence_req;
        if (!frame_ok || !sender_ok) begin
            o_class.status = ST_IGNORED;
        end else if (count_bad) begin
            o_class.status = ST_INVALID;
        end else begin
            o_class.status = ST_ACCEPTED;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/plnc_node_ram.sv =====
// Per-node record memory with registered read and per-entry valid bits.
`timescale 1ns / 1ps
`default_nettype none

module plnc_node_ram #(
    parameter int NODES = 8,
    parameter int IDX_W = 3
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_rd_en,
    input  logic [IDX_W-1:0]     i_rd_idx,
    output plnc_pkg::t_entry     o_rd_data,
    input  logic                 i_wr_en,
    input  logic [IDX_W-1:0]     i_wr_idx,
    input  plnc_pkg::t_entry     i_wr_data
);
    import plnc_pkg::*;

    t_entry           r_mem [NODES];
    logic [NODES-1:0] r_valid;
    t_entry           r_rd_data;
    logic             r_rd_valid;

    // Entries never written since reset read back as all zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr_en) begin
            r_valid[i_wr_idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_idx] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data  <= r_mem[i_rd_idx];
            r_rd_valid <= r_valid[i_rd_idx];
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule

`default_nettype wire

// ===== hw/rtl/plnc_update.sv =====
// Counter and sequence-gap update of one node record.
`timescale 1ns / 1ps
`default_nettype none

module plnc_update (
    input  plnc_pkg::t_class  i_class,
    input  plnc_pkg::t_entry  i_entry,
    output plnc_pkg::t_entry  o_entry,
    output plnc_pkg::t_result o_result
);
    import plnc_pkg::*;

    logic [SEQ_W-1:0] gap;
    logic [SEQ_W-1:0] missed;

    always_comb begin
        gap    = i_class.seq - i_entry.last_seq;
        // A stored sequence of zero means nothing seen yet, so no loss is counted.
        missed = ((i_entry.last_seq != '0) && (gap > 16'd1)) ? gap - 16'd1 : '0;

        o_entry = i_entry;
        o_result = '0;
        if (i_class.status == ST_ACCEPTED) begin
            o_entry.last_seq = i_class.seq;
            o_entry.packets  = i_entry.packets + 32'd1;
            o_entry.samples  = i_entry.samples + {24'd0, i_class.count};
            o_entry.lost     = i_entry.lost + {16'd0, missed};
        end else if (i_class.status == ST_INVALID) begin
            o_entry.invalid  = i_entry.invalid + 32'd1;
        end

        if (i_class.status != ST_IGNORED) begin
            o_result.status            = i_class.status;
            o_result.node_index        = i_class.node;
            o_result.missed_packets    = (i_class.status == ST_ACCEPTED) ? missed : '0;
            o_result.previous_sequence = i_entry.last_seq;
            o_result.packets_total     = o_entry.packets;
            o_result.samples_total     = o_entry.samples;
            o_result.lost_total        = o_entry.lost;
            o_result.invalid_total     = o_entry.invalid;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/per_node_packet_loss_accounting_top.sv =====
// Top level of the per-node packet loss accounting block.
//
//  Channel   Direction  Handshake            Content
//  i_req     in         valid/ready          one received frame header
//  o_rsp     out        valid/ready          status and the node's updated totals
//  i_cfg_*   in         write enable only    data type code, reset value 1
//
// One request is taken per cycle when the result side keeps up; a result is
// held in the update stage and then in the output register. The node memory's
// single read port is read as a request is taken; the update stage writes back
// as its result moves out, with the last write forwarded to a following request
// for the same node. Reset clears the per-node valid bits at once; no clearing
// pass is needed. A stalled result holds one request in the update stage and blocks further ones.
`timescale 1ns / 1ps
`default_nettype none

module per_node_packet_loss_accounting_top #(
    parameter int NODES        = 8,
    parameter int HEADER_BYTES = 16,
    parameter int MAX_SAMPLES  = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [7:0]  i_cfg_wr_data,
    plnc_req_if.sink    i_req,
    plnc_rsp_if.source  o_rsp
);
    import plnc_pkg::*;

    localparam int IDX_W = (NODES > 1) ? $clog2(NODES) : 1;

    logic [7:0]       r_data_type_code;
    logic             r_s1_valid;
    t_class           r_s1;
    logic             r_out_valid;
    t_result          r_out;
    logic             r_fw_valid;
    logic [IDX_W-1:0] r_fw_idx;
    t_entry           r_fw_data;

    t_class           n_class;
    t_entry           rd_data;
    t_entry           cur_entry;
    t_entry           n_entry;
    t_result          n_out;
    logic             advance;
    logic             req_take;
    logic             wr_en;
    logic [IDX_W-1:0] s1_idx;
    logic [IDX_W-1:0] rd_idx;

    plnc_classify #(
        .NODES        (NODES),
        .HEADER_BYTES (HEADER_BYTES),
        .MAX_SAMPLES  (MAX_SAMPLES)
    ) u_classify (
        .i_data_type_code (r_data_type_code),
        .i_frame_type     (i_req.frame_type),
        .i_frame_length   (i_req.frame_length),
        .i_src_node       (i_req.src_node),
        .i_sequence_req   (i_req.sequence_req),
        .i_smp_count      (i_req.smp_count),
        .o_class          (n_class)
    );

    assign advance  = !r_out_valid || o_rsp.ready;
    assign req_take = i_req.valid && i_req.ready;
    assign rd_idx   = IDX_W'(n_class.node);
    assign s1_idx   = IDX_W'(r_s1.node);
    assign wr_en    = r_s1_valid && advance && (r_s1.status != ST_IGNORED);

    assign i_req.ready = !r_s1_valid || advance;

    plnc_node_ram #(
        .NODES (NODES),
        .IDX_W (IDX_W)
    ) u_node_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (req_take),
        .i_rd_idx  (rd_idx),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_idx  (s1_idx),
        .i_wr_data (n_entry)
    );

    // The memory read may have missed the write of the request just ahead.
    assign cur_entry = (r_fw_valid && (r_fw_idx == s1_idx)) ? r_fw_data : rd_data;

    plnc_update u_update (
        .i_class  (r_s1),
        .i_entry  (cur_entry),
        .o_entry  (n_entry),
        .o_result (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data_type_code <= 8'd1;
            r_s1_valid       <= 1'b0;
            r_out_valid      <= 1'b0;
            r_fw_valid       <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_data_type_code <= i_cfg_wr_data;
            end
            if (req_take) begin
                r_s1_valid <= 1'b1;
            end else if (advance) begin
                r_s1_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= r_s1_valid;
            end
            if (wr_en) begin
                r_fw_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_take) begin
            r_s1 <= n_class;
        end
        if (r_s1_valid && advance) begin
            r_out <= n_out;
        end
        if (wr_en) begin
            r_fw_idx  <= s1_idx;
            r_fw_data <= n_entry;
        end
    end

    assign o_rsp.valid             = r_out_valid;
    assign o_rsp.status            = r_out.status;
    assign o_rsp.node_index        = r_out.node_index;
    assign o_rsp.missed_packets    = r_out.missed_packets;
    assign o_rsp.previous_sequence = r_out.previous_sequence;
    assign o_rsp.packets_total     = r_out.packets_total;
    assign o_rsp.samples_total     = r_out.samples_total;
    assign o_rsp.lost_total        = r_out.lost_total;
    assign o_rsp.invalid_total     = r_out.invalid_total;

endmodule

`default_nettype wire

// ===== hw/rtl/plnc_checker.sv =====
// Port-level assertions for the packet loss accounting top level, and their binding.
`timescale 1ns / 1ps
`default_nettype none

module plnc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_rsp_valid,
    input logic        i_rsp_ready,
    input logic [1:0]  i_status,
    input logic [5:0]  i_node_index,
    input logic [15:0] i_missed_packets,
    input logic [15:0] i_previous_sequence,
    input logic [31:0] i_packets_total,
    input logic [31:0] i_samples_total,
    input logic [31:0] i_lost_total,
    input logic [31:0] i_invalid_total
);
    import plnc_pkg::*;

    a_reset_clears_result: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("result valid right after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_status)
            && $stable(i_node_index) && $stable(i_missed_packets)
            && $stable(i_previous_sequence) && $stable(i_packets_total)
            && $stable(i_samples_total) && $stable(i_lost_total)
            && $stable(i_invalid_total))
        else $error("stalled result changed");

    a_ignored_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_status == ST_IGNORED) |-> (i_node_index == '0)
            && (i_missed_packets == '0) && (i_previous_sequence == '0)
            && (i_packets_total == '0) && (i_samples_total == '0)
            && (i_lost_total == '0) && (i_invalid_total == '0))
        else $error("ignored frame carries node data");

    a_loss_needs_history: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_missed_packets != '0) |-> (i_status == ST_ACCEPTED)
            && (i_previous_sequence != '0))
        else $error("loss reported without an accepted frame and stored sequence");

endmodule

bind per_node_packet_loss_accounting_top plnc_checker u_plnc_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_rsp_valid         (o_rsp.valid),
    .i_rsp_ready         (o_rsp.ready),
    .i_status            (o_rsp.status),
    .i_node_index        (o_rsp.node_index),
    .i_missed_packets    (o_rsp.missed_packets),
    .i_previous_sequence (o_rsp.previous_sequence),
    .i_packets_total     (o_rsp.packets_total),
    .i_samples_total     (o_rsp.samples_total),
    .i_lost_total        (o_rsp.lost_total),
    .i_invalid_total     (o_rsp.invalid_total)
);

`default_nettype wire
